/* hdl/ocmm_pkg.sv */
package ocmm_pkg;

    localparam int SHORT_WINDOW = 5;
    localparam int LONG_WINDOW  = 10;

    localparam int USAGE_W  = 15;
    localparam int TIME_W   = 32;
    localparam int PERIOD_W = 16;
    localparam int MACD_W   = 24;

    localparam logic [USAGE_W-1:0]  FULL_SCALE   = USAGE_W'(25600);
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(1);

    localparam int HIST_DEPTH = (SHORT_WINDOW > LONG_WINDOW) ? SHORT_WINDOW : LONG_WINDOW;
    localparam int PTR_W      = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;

    localparam int MACD_START = 27;
    localparam int COUNT_SAT  = (HIST_DEPTH > MACD_START) ? HIST_DEPTH : MACD_START;
    localparam int CNT_W      = $clog2(COUNT_SAT + 1);

    localparam logic [CNT_W-1:0] CNT_SAT   = CNT_W'(COUNT_SAT);
    localparam logic [CNT_W-1:0] CNT_SHORT = CNT_W'(SHORT_WINDOW);
    localparam logic [CNT_W-1:0] CNT_LONG  = CNT_W'(LONG_WINDOW);
    localparam logic [CNT_W-1:0] CNT_MACD  = CNT_W'(MACD_START);

    // window sums and reciprocal constants for the floor means
    localparam int SSUM_W = $clog2(25600 * SHORT_WINDOW + 1);
    localparam int LSUM_W = $clog2(25600 * LONG_WINDOW + 1);

    localparam int SSHIFT = SSUM_W + $clog2(SHORT_WINDOW);
    localparam int LSHIFT = LSUM_W + $clog2(LONG_WINDOW);

    localparam longint SRECIP_VAL = ((longint'(1) << SSHIFT) + SHORT_WINDOW - 1) / SHORT_WINDOW;
    localparam longint LRECIP_VAL = ((longint'(1) << LSHIFT) + LONG_WINDOW - 1) / LONG_WINDOW;

    localparam int SRECIP_W = $clog2(SRECIP_VAL + 1);
    localparam int LRECIP_W = $clog2(LRECIP_VAL + 1);

    localparam logic [SRECIP_W-1:0] SRECIP = SRECIP_W'(SRECIP_VAL);
    localparam logic [LRECIP_W-1:0] LRECIP = LRECIP_W'(LRECIP_VAL);

    localparam int SPROD_W = SSUM_W + SRECIP_W;
    localparam int LPROD_W = LSUM_W + LRECIP_W;

    // ema arithmetic, 16 fraction bits of percent
    localparam int EMA_W   = USAGE_W + 8;
    localparam int COEF_W  = 14;
    localparam int FRAC_W  = 16;
    localparam int DIFF_W  = EMA_W + 1;
    localparam int PROD_W  = DIFF_W + COEF_W + 1;
    localparam int STEP_W  = EMA_W + 2;

    localparam logic [EMA_W-1:0]  EMA_MAX   = EMA_W'(6553600);
    localparam logic [COEF_W-1:0] COEF_FAST = COEF_W'(10082);
    localparam logic [COEF_W-1:0] COEF_SLOW = COEF_W'(4855);
    localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1 << (FRAC_W - 1));

    typedef logic [USAGE_W-1:0]       t_usage;
    typedef logic [TIME_W-1:0]        t_time;
    typedef logic [PERIOD_W-1:0]      t_period;
    typedef logic [PTR_W-1:0]         t_ptr;
    typedef logic [EMA_W-1:0]         t_ema;
    typedef logic [COEF_W-1:0]        t_coef;
    typedef logic signed [MACD_W-1:0] t_macd;

    typedef struct packed {
        t_usage              bar_open;
        t_usage              bar_high;
        t_usage              bar_low;
        t_usage              bar_close;
        t_time               bar_time;
        logic [SSUM_W-1:0]   short_sum;
        logic                short_ok;
        logic [LSUM_W-1:0]   long_sum;
        logic                long_ok;
        t_macd               macd_value;
        logic                macd_ok;
    } t_stage;

endpackage

/* hdl/ocmm_if.sv */
interface ocmm_sample_if;
    import ocmm_pkg::*;

    logic   valid;
    logic   ready;
    t_usage usage;
    t_time  now_seconds;

    modport source (output valid, usage, now_seconds, input ready);
    modport sink (input valid, usage, now_seconds, output ready);
endinterface

interface ocmm_result_if;
    import ocmm_pkg::*;

    logic   valid;
    logic   ready;
    t_usage bar_open;
    t_usage bar_high;
    t_usage bar_low;
    t_usage bar_close;
    t_time  bar_time;
    t_usage mean_short;
    logic   mean_short_valid;
    t_usage mean_long;
    logic   mean_long_valid;
    t_macd  macd_value;
    logic   macd_valid;

    modport source (
        output valid, bar_open, bar_high, bar_low, bar_close, bar_time,
               mean_short, mean_short_valid, mean_long, mean_long_valid,
               macd_value, macd_valid,
        input  ready
    );
    modport sink (
        input  valid, bar_open, bar_high, bar_low, bar_close, bar_time,
               mean_short, mean_short_valid, mean_long, mean_long_valid,
               macd_value, macd_valid,
        output ready
    );
endinterface

interface ocmm_cfg_if;
    import ocmm_pkg::*;

    logic    valid;
    logic    ready;
    t_period data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

/* hdl/ocmm_hist_ram.sv */
module ocmm_hist_ram (
    input  logic            i_clk,
    input  logic            i_we,
    input  ocmm_pkg::t_ptr   i_waddr,
    input  ocmm_pkg::t_usage i_wdata,
    input  ocmm_pkg::t_ptr   i_raddr_a,
    input  ocmm_pkg::t_ptr   i_raddr_b,
    output ocmm_pkg::t_usage o_rdata_a,
    output ocmm_pkg::t_usage o_rdata_b
);
    import ocmm_pkg::*;

    t_usage mem [HIST_DEPTH];
    t_usage r_rdata_a;
    t_usage r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= mem[i_raddr_a];
        r_rdata_b <= mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;
endmodule

/* hdl/ocmm_ema.sv */
module ocmm_ema (
    input  ocmm_pkg::t_ema  i_ema,
    input  ocmm_pkg::t_ema  i_x,
    input  ocmm_pkg::t_coef i_coef,
    output ocmm_pkg::t_ema  o_ema
);
    import ocmm_pkg::*;

    logic signed [DIFF_W-1:0] diff;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] rnd;
    logic signed [STEP_W-1:0] step;
    logic signed [STEP_W-1:0] sum;

    always_comb begin
        diff = $signed({1'b0, i_x}) - $signed({1'b0, i_ema});
        prod = diff * $signed({1'b0, i_coef});
        rnd  = prod + ROUND_HALF;
        step = STEP_W'(rnd >>> FRAC_W);
        sum  = $signed({2'b00, i_ema}) + step;
        if (sum[STEP_W-1]) begin
            o_ema = '0;
        end else if (sum > $signed({2'b00, EMA_MAX})) begin
            o_ema = EMA_MAX;
        end else begin
            o_ema = sum[EMA_W-1:0];
        end
    end
endmodule

/* hdl/ocmm_out_stage.sv */
module ocmm_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  ocmm_pkg::t_stage i_stage,
    output logic             o_free,
    ocmm_result_if.source    o_result
);
    import ocmm_pkg::*;

    logic               r_valid;
    t_stage             r_stage;
    t_usage             r_mean_short;
    t_usage             r_mean_long;
    logic [SPROD_W-1:0] sprod;
    logic [LPROD_W-1:0] lprod;
    t_usage             n_mean_short;
    t_usage             n_mean_long;

    assign o_free = !r_valid || o_result.ready;

    // floor mean by reciprocal multiply
    always_comb begin
        sprod = SPROD_W'(i_stage.short_sum) * SPROD_W'(SRECIP);
        lprod = LPROD_W'(i_stage.long_sum) * LPROD_W'(LRECIP);
        n_mean_short = i_stage.short_ok ? USAGE_W'(sprod >> SSHIFT) : '0;
        n_mean_long  = i_stage.long_ok ? USAGE_W'(lprod >> LSHIFT) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_valid) begin
            r_stage      <= i_stage;
            r_mean_short <= n_mean_short;
            r_mean_long  <= n_mean_long;
        end
    end

    assign o_result.valid            = r_valid;
    assign o_result.bar_open         = r_stage.bar_open;
    assign o_result.bar_high         = r_stage.bar_high;
    assign o_result.bar_low          = r_stage.bar_low;
    assign o_result.bar_close        = r_stage.bar_close;
    assign o_result.bar_time         = r_stage.bar_time;
    assign o_result.mean_short       = r_mean_short;
    assign o_result.mean_short_valid = r_stage.short_ok;
    assign o_result.mean_long        = r_mean_long;
    assign o_result.mean_long_valid  = r_stage.long_ok;
    assign o_result.macd_value       = r_stage.macd_value;
    assign o_result.macd_valid       = r_stage.macd_ok;
endmodule

/* hdl/ohlc_candle_ma_macd_unit.sv */
// Builds open/high/low/close bars from timestamped Q7.8 percent samples and, for every
// closed bar, returns the bar with its 5- and 10-close floor means and the MACD of the
// 12/26 EMAs. One sample is taken per clock cycle while the result stage can move on; a
// closing sample's result passes the result stage and the output register to o_result
// and stays until taken. The rate is set by the close update: the window sums read the
// leaving closes from the history RAM, whose two registered read ports are fetched ahead
// for the next pointer, and each EMA does its one multiply combinationally in that update.
// The period register may be written at any time the block is idle; i_cfg is always ready.
module ohlc_candle_ma_macd_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ocmm_cfg_if.sink      i_cfg,
    ocmm_sample_if.sink   i_sample,
    ocmm_result_if.source o_result
);
    import ocmm_pkg::*;

    logic              r_started;
    t_time             r_start;
    t_usage            r_open;
    t_usage            r_high;
    t_usage            r_low;
    t_ptr              r_ptr;
    logic [SSUM_W-1:0] r_short_sum;
    logic [LSUM_W-1:0] r_long_sum;
    logic [CNT_W-1:0]  r_count;
    t_ema              r_fast;
    t_ema              r_slow;
    t_period           r_period;
    logic              r_s1_valid;
    t_stage            r_s1;

    logic              in_fire;
    logic              close_fire;
    logic              out_free;
    t_usage            u_sat;
    t_usage            hi;
    t_usage            lo;
    t_time             elapsed;
    logic              is_close;
    t_ptr              ptr_inc;
    t_ptr              n_ptr;
    logic [PTR_W:0]    raddr_s_w;
    logic [PTR_W:0]    raddr_l_w;
    t_ptr              raddr_s;
    t_ptr              raddr_l;
    t_usage            rd_s;
    t_usage            rd_l;
    logic [CNT_W-1:0]  cnt_inc;
    logic [SSUM_W-1:0] n_short_sum;
    logic [LSUM_W-1:0] n_long_sum;
    logic              macd_ok;
    t_ema              ema_x;
    t_ema              fast_n;
    t_ema              slow_n;
    t_macd             macd;
    t_stage            n_s1;

    assign i_cfg.ready    = 1'b1;
    assign i_sample.ready = !r_s1_valid || out_free;
    assign in_fire        = i_sample.valid && i_sample.ready;

    always_comb begin
        u_sat    = (i_sample.usage > FULL_SCALE) ? FULL_SCALE : i_sample.usage;
        hi       = (u_sat > r_high) ? u_sat : r_high;
        lo       = (u_sat < r_low) ? u_sat : r_low;
        elapsed  = i_sample.now_seconds - r_start;
        is_close = r_started && (elapsed >= TIME_W'(r_period));
    end

    assign close_fire = in_fire && is_close;

    // history pointer and prefetch addresses for the next close
    always_comb begin
        ptr_inc   = (r_ptr == PTR_W'(HIST_DEPTH - 1)) ? '0 : r_ptr + PTR_W'(1);
        n_ptr     = close_fire ? ptr_inc : r_ptr;
        raddr_s_w = {1'b0, n_ptr} + (PTR_W+1)'(HIST_DEPTH - SHORT_WINDOW);
        raddr_l_w = {1'b0, n_ptr} + (PTR_W+1)'(HIST_DEPTH - LONG_WINDOW);
        if (raddr_s_w >= (PTR_W+1)'(HIST_DEPTH)) begin
            raddr_s_w = raddr_s_w - (PTR_W+1)'(HIST_DEPTH);
        end
        if (raddr_l_w >= (PTR_W+1)'(HIST_DEPTH)) begin
            raddr_l_w = raddr_l_w - (PTR_W+1)'(HIST_DEPTH);
        end
        raddr_s = raddr_s_w[PTR_W-1:0];
        raddr_l = raddr_l_w[PTR_W-1:0];
    end

    ocmm_hist_ram u_hist (
        .i_clk     (i_clk),
        .i_we      (close_fire),
        .i_waddr   (r_ptr),
        .i_wdata   (u_sat),
        .i_raddr_a (raddr_s),
        .i_raddr_b (raddr_l),
        .o_rdata_a (rd_s),
        .o_rdata_b (rd_l)
    );

    always_comb begin
        cnt_inc     = (r_count < CNT_SAT) ? r_count + CNT_W'(1) : r_count;
        n_short_sum = r_short_sum - ((r_count >= CNT_SHORT) ? SSUM_W'(rd_s) : '0)
                      + SSUM_W'(u_sat);
        n_long_sum  = r_long_sum - ((r_count >= CNT_LONG) ? LSUM_W'(rd_l) : '0)
                      + LSUM_W'(u_sat);
        macd_ok     = cnt_inc >= CNT_MACD;
        ema_x       = {u_sat, 8'h00};
    end

    ocmm_ema u_fast (
        .i_ema  (r_fast),
        .i_x    (ema_x),
        .i_coef (COEF_FAST),
        .o_ema  (fast_n)
    );

    ocmm_ema u_slow (
        .i_ema  (r_slow),
        .i_x    (ema_x),
        .i_coef (COEF_SLOW),
        .o_ema  (slow_n)
    );

    always_comb begin
        macd = macd_ok ? ($signed({1'b0, fast_n}) - $signed({1'b0, slow_n})) : '0;
        n_s1.bar_open   = r_open;
        n_s1.bar_high   = hi;
        n_s1.bar_low    = lo;
        n_s1.bar_close  = u_sat;
        n_s1.bar_time   = i_sample.now_seconds;
        n_s1.short_sum  = n_short_sum;
        n_s1.short_ok   = cnt_inc >= CNT_SHORT;
        n_s1.long_sum   = n_long_sum;
        n_s1.long_ok    = cnt_inc >= CNT_LONG;
        n_s1.macd_value = macd;
        n_s1.macd_ok    = macd_ok;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= PERIOD_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_period <= i_cfg.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started   <= 1'b0;
            r_start     <= '0;
            r_open      <= '0;
            r_high      <= '0;
            r_low       <= '0;
            r_ptr       <= '0;
            r_short_sum <= '0;
            r_long_sum  <= '0;
            r_count     <= '0;
            r_fast      <= '0;
            r_slow      <= '0;
        end else if (in_fire) begin
            r_started <= 1'b1;
            if (!r_started || is_close) begin
                r_start <= i_sample.now_seconds;
                r_open  <= u_sat;
                r_high  <= u_sat;
                r_low   <= u_sat;
            end else begin
                r_high <= hi;
                r_low  <= lo;
            end
            if (is_close) begin
                r_ptr       <= ptr_inc;
                r_short_sum <= n_short_sum;
                r_long_sum  <= n_long_sum;
                r_count     <= cnt_inc;
                if (macd_ok) begin
                    r_fast <= fast_n;
                    r_slow <= slow_n;
                end
            end
        end
    end

    // result stage ahead of the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (close_fire) begin
            r_s1_valid <= 1'b1;
        end else if (out_free) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (close_fire) begin
            r_s1 <= n_s1;
        end
    end

    ocmm_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_s1_valid),
        .i_stage  (r_s1),
        .o_free   (out_free),
        .o_result (o_result)
    );
endmodule

/* test/ocmm_bar_checker.sv */
module ocmm_bar_checker (
    input  logic   i_clk,
    input  logic   i_rst_n,
    ocmm_cfg_if    cfg_bus,
    ocmm_sample_if smp_bus,
    ocmm_result_if res_bus,
    output int     o_fails,
    output int     o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import ocmm_pkg::*;

    localparam longint FAST_COEF = 10082;
    localparam longint SLOW_COEF = 4855;
    localparam longint EMA_TOP   = 6553600;

    typedef logic signed [63:0] t_wide;

    typedef struct {
        t_usage bar_open;
        t_usage bar_high;
        t_usage bar_low;
        t_usage bar_close;
        t_time  bar_time;
        t_usage mean_short;
        logic   mean_short_valid;
        t_usage mean_long;
        logic   mean_long_valid;
        t_macd  macd_value;
        logic   macd_valid;
    } t_bar;

    t_bar    bars_due[$];
    t_bar    head_bar;
    int      fail_total;
    int      due_count;

    // mirror of the block state
    t_period period_q;
    logic    bar_open_q;
    t_time   start_t;
    t_usage  open_v;
    t_usage  high_v;
    t_usage  low_v;
    t_usage  closes[HIST_DEPTH];
    int      wr_ptr;
    int      closed_bars;
    int      short_total;
    int      long_total;
    longint  fast_ema;
    longint  slow_ema;

    assign o_fails   = fail_total;
    assign o_pending = due_count;

    initial begin
        fail_total = 0;
        due_count  = 0;
    end

    function automatic longint ema_step(input longint avg, input longint x, input longint coef);
        longint r;
        r = avg + (((x - avg) * coef + 64'sd32768) >>> 16);
        if (r < 0) r = 0;
        if (r > EMA_TOP) r = EMA_TOP;
        return r;
    endfunction

    function automatic void check_field(input string name, input t_wide want, input t_wide got);
        if (want !== got) begin
            $display("%0t %s: expected %0d, actual %0d", $time, name, want, got);
            fail_total++;
        end
    endfunction

    task automatic take_sample(input t_usage raw, input t_time t);
        t_usage u;
        t_time  elapsed;
        t_bar   b;
        u = (raw > FULL_SCALE) ? FULL_SCALE : raw;
        if (!bar_open_q) begin
            bar_open_q = 1'b1;
            open_v     = u;
            high_v     = u;
            low_v      = u;
            start_t    = t;
            return;
        end
        if (u > high_v) high_v = u;
        if (u < low_v) low_v = u;
        elapsed = t - start_t;
        if (elapsed < TIME_W'(period_q)) return;

        if (closed_bars >= SHORT_WINDOW)
            short_total -= int'(closes[(wr_ptr + HIST_DEPTH - SHORT_WINDOW) % HIST_DEPTH]);
        if (closed_bars >= LONG_WINDOW)
            long_total -= int'(closes[(wr_ptr + HIST_DEPTH - LONG_WINDOW) % HIST_DEPTH]);
        short_total += int'(u);
        long_total  += int'(u);
        closes[wr_ptr] = u;
        wr_ptr = (wr_ptr + 1) % HIST_DEPTH;
        if (closed_bars < COUNT_SAT) closed_bars++;

        b.macd_value = '0;
        if (closed_bars >= MACD_START) begin
            fast_ema = ema_step(fast_ema, longint'(u) * 256, FAST_COEF);
            slow_ema = ema_step(slow_ema, longint'(u) * 256, SLOW_COEF);
            b.macd_value = t_macd'(fast_ema - slow_ema);
        end

        b.bar_open         = open_v;
        b.bar_high         = high_v;
        b.bar_low          = low_v;
        b.bar_close        = u;
        b.bar_time         = t;
        b.mean_short_valid = (closed_bars >= SHORT_WINDOW);
        b.mean_short       = b.mean_short_valid ? t_usage'(short_total / SHORT_WINDOW) : '0;
        b.mean_long_valid  = (closed_bars >= LONG_WINDOW);
        b.mean_long        = b.mean_long_valid ? t_usage'(long_total / LONG_WINDOW) : '0;
        b.macd_valid       = (closed_bars >= MACD_START);
        bars_due.insert(bars_due.size(), b);

        open_v  = u;
        high_v  = u;
        low_v   = u;
        start_t = t;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            period_q    = PERIOD_RESET;
            bar_open_q  = 1'b0;
            start_t     = '0;
            open_v      = '0;
            high_v      = '0;
            low_v       = '0;
            wr_ptr      = 0;
            closed_bars = 0;
            short_total = 0;
            long_total  = 0;
            fast_ema    = 0;
            slow_ema    = 0;
            foreach (closes[k]) closes[k] = '0;
            bars_due.delete();
        end else begin
            if (cfg_bus.valid && cfg_bus.ready) period_q = cfg_bus.data;
            // results first: a sample never completes in the beat it is taken
            if (res_bus.valid && res_bus.ready) begin
                if (bars_due.size() == 0) begin
                    $display("%0t bar beat: expected none, actual bar_close %0d time %0d",
                             $time, res_bus.bar_close, res_bus.bar_time);
                    fail_total++;
                end else begin
                    head_bar = bars_due.pop_front();
                    check_field("bar_open", head_bar.bar_open, res_bus.bar_open);
                    check_field("bar_high", head_bar.bar_high, res_bus.bar_high);
                    check_field("bar_low", head_bar.bar_low, res_bus.bar_low);
                    check_field("bar_close", head_bar.bar_close, res_bus.bar_close);
                    check_field("bar_time", head_bar.bar_time, res_bus.bar_time);
                    check_field("mean_short", head_bar.mean_short, res_bus.mean_short);
                    check_field("mean_short_valid", head_bar.mean_short_valid,
                                res_bus.mean_short_valid);
                    check_field("mean_long", head_bar.mean_long, res_bus.mean_long);
                    check_field("mean_long_valid", head_bar.mean_long_valid,
                                res_bus.mean_long_valid);
                    check_field("macd_value", head_bar.macd_value, res_bus.macd_value);
                    check_field("macd_valid", head_bar.macd_valid, res_bus.macd_valid);
                end
            end
            if (smp_bus.valid && smp_bus.ready) take_sample(smp_bus.usage, smp_bus.now_seconds);
        end
        due_count = bars_due.size();
    end

endmodule

/* test/tb_ohlc_candle_ma_macd_unit.sv */
module tb_ohlc_candle_ma_macd_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import ocmm_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic  i_clk;
    logic  i_rst_n;
    int    fail_count;
    int    bars_pending;
    int    cycle_count;
    bit    calm;
    t_time now_t;

    ocmm_cfg_if    cfg_ch ();
    ocmm_sample_if sample_ch ();
    ocmm_result_if result_ch ();

    ohlc_candle_ma_macd_unit u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg_ch),
        .i_sample (sample_ch),
        .o_result (result_ch)
    );

    ocmm_bar_checker u_check (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .cfg_bus   (cfg_ch),
        .smp_bus   (sample_ch),
        .res_bus   (result_ch),
        .o_fails   (fail_count),
        .o_pending (bars_pending)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("ohlc_candle_ma_macd_unit: mismatch");
        $finish;
    end

    // result side back-pressure
    initial begin
        result_ch.ready = 1'b1;
        forever begin
            repeat ($urandom_range(1, 60)) @(posedge i_clk);
            if (!calm && $urandom_range(0, 1) == 1) begin
                result_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
                result_ch.ready <= 1'b1;
            end
        end
    end

    function automatic t_usage pick_usage();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return FULL_SCALE;
            2: return t_usage'($urandom_range(25601, 32767));
            default: return t_usage'($urandom_range(0, 25600));
        endcase
    endfunction

    task automatic send_sample(input t_usage u, input t_time t, input int gap_pct);
        if (!calm && $urandom_range(0, 99) < gap_pct) begin
            sample_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        sample_ch.valid       <= 1'b1;
        sample_ch.usage       <= u;
        sample_ch.now_seconds <= t;
        do @(posedge i_clk); while (!sample_ch.ready);
    endtask

    // wait until every bar is out and the pipeline has emptied
    task automatic settle();
        sample_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (bars_pending != 0) @(negedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_period(input t_period p);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= p;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic run_phase(input int n, input t_period p, input bit quiet);
        int kind;
        int gap_pct;
        int step_max;
        step_max = int'(p) / 2 + 1;
        gap_pct  = 0;
        for (int k = 0; k < n; k++) begin
            if (k % 32 == 0) gap_pct = quiet ? 0 : 25 * int'($urandom_range(0, 2));
            kind = int'($urandom_range(0, 99));
            if (kind < 90)
                now_t = now_t + t_time'($urandom_range(0, step_max));
            else if (kind < 95)
                now_t = now_t - t_time'($urandom_range(1, 1000));
            else
                now_t = t_time'($urandom());
            send_sample(pick_usage(), now_t, gap_pct);
        end
    endtask

    initial begin
        t_period p;
        i_rst_n               = 1'b0;
        calm                  = 1'b0;
        now_t                 = '0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.data           = '0;
        sample_ch.valid       = 1'b0;
        sample_ch.usage       = '0;
        sample_ch.now_seconds = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, reset period of one second
        send_sample(15'd0, 32'd1000, 25);
        send_sample(15'd25600, 32'd1000, 25);
        send_sample(15'd32767, 32'd1000, 25);
        send_sample(15'd25601, 32'd1000, 25);
        send_sample(15'd0, 32'd1001, 25);
        send_sample(15'd12345, 32'd1001, 25);
        send_sample(15'd100, 32'd1002, 25);
        send_sample(15'd32767, 32'd1003, 25);
        send_sample(15'd500, 32'd900, 25);
        send_sample(15'd7, 32'hFFFF_FFFF, 25);
        send_sample(15'd8, 32'd0, 25);
        send_sample(15'd9, 32'd0, 25);
        for (int k = 1; k <= 13; k++)
            send_sample(t_usage'((k * 1979) % 25601), t_time'(k), 25);
        now_t = 32'd13;
        settle();

        write_period(16'd0);
        run_phase(200, 16'd0, 1'b0);
        settle();

        write_period(16'd1);
        run_phase(250, 16'd1, 1'b0);
        settle();

        write_period(16'hFFFF);
        run_phase(250, 16'hFFFF, 1'b0);
        settle();

        p = t_period'($urandom_range(2, 20));
        write_period(p);
        run_phase(250, p, 1'b0);
        settle();

        p = t_period'($urandom_range(1, 65535));
        write_period(p);
        run_phase(200, p, 1'b0);
        settle();

        // no idling from here on
        calm = 1'b1;
        write_period(16'd3);
        run_phase(250, 16'd3, 1'b1);
        settle();

        repeat (8) @(posedge i_clk);
        if (fail_count == 0)
            $display("ohlc_candle_ma_macd_unit: match");
        else
            $display("ohlc_candle_ma_macd_unit: mismatch");
        $finish;
    end

endmodule

/* sim.f */
hdl/ocmm_pkg.sv
hdl/ocmm_if.sv
hdl/ocmm_hist_ram.sv
hdl/ocmm_ema.sv
hdl/ocmm_out_stage.sv
hdl/ohlc_candle_ma_macd_unit.sv
test/ocmm_bar_checker.sv
test/tb_ohlc_candle_ma_macd_unit.sv
